### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// concurrent assertion helpers, empty bodies for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hdl/wrm_pkg.sv
// ----------------------------------------------------------------------------
// wrm_pkg
// shared types and constants of the windowed rms meter
// ----------------------------------------------------------------------------
package wrm_pkg;

   localparam int MAX_WINDOW = 1024;
   localparam int WIN_W      = 11;
   localparam int SUM_W      = 41;
   localparam int SQ_W       = 31;
   localparam int ACC_W      = 42;
   localparam int REM_W      = 26;
   localparam int ROOT_W     = 21;
   localparam int WQ_W       = 17;
   localparam int STEP_W     = 6;

   localparam logic [STEP_W-1:0] WDIV_STEPS = STEP_W'(WQ_W);
   localparam logic [STEP_W-1:0] MDIV_STEPS = STEP_W'(ACC_W);
   localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(ROOT_W);

   localparam logic OP_DIV  = 1'b0;
   localparam logic OP_SQRT = 1'b1;

   localparam logic [15:0] RATE_RESET = 16'd20000;

   localparam logic REG_SAMPLE_RATE = 1'b0;

   typedef struct packed {
      logic signed [15:0] sample;
      logic [15:0]        freq;
   } req_word_type;

   typedef struct packed {
      logic [15:0] rms;
      logic        fresh;
   } rsp_word_type;

   typedef struct packed {
      logic              start;
      logic              op;
      logic [STEP_W-1:0] steps;
      logic [ACC_W-1:0]  dividend;
      logic [15:0]       divisor;
   } arith_cmd_type;

endpackage

### hdl/windowed_rms_meter_core.sv
// ----------------------------------------------------------------------------
// windowed_rms_meter_core
// block rms over one period of the fundamental, computed by a shared
// bit-serial divide and square root unit
// ----------------------------------------------------------------------------
// usage
//   req channel: one word carries a signed sample and the fundamental freq;
//   rsp channel: one word per request with the latest rms and a fresh flag.
//   apb port: register 0 at address 0 is sample_rate; the user must write it
//   only while idle, as the block itself does not enforce this.
// sequencing
//   freq of zero: no arithmetic, the result goes straight to the output register
//   window still open: 17-step window divide, square, update, then output
//   window closes: adds a 42-step mean divide and a 21-step square root;
//   the shared unit serves one request at a time, since req_ready is high
//   only in idle; req_ready rises at the edge that loads the output
//   register
// reset
//   sample_rate returns to 20000, stored freq, sum, count and rms clear
// stall
//   a result held by a low rsp_ready still lets the next request in; that
//   request's own result waits until the output register is free
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module windowed_rms_meter_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  wrm_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output wrm_pkg::rsp_word_type rsp_word,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WDIV  = 3'd1;
   localparam logic [2:0] ST_ACCUM = 3'd2;
   localparam logic [2:0] ST_MDIV  = 3'd3;
   localparam logic [2:0] ST_SQRT  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]                    state_ff, state_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   wrm_pkg::rsp_word_type         rsp_word_ff, rsp_word_in;
   logic [15:0]                   sample_rate_ff, sample_rate_in;
   logic [15:0]                   stored_freq_ff, stored_freq_in;
   logic [wrm_pkg::SUM_W-1:0]     square_sum_ff, square_sum_in;
   logic [wrm_pkg::WIN_W-1:0]     sample_count_ff, sample_count_in;
   logic [15:0]                   held_rms_ff, held_rms_in;
   logic                          fresh_ff, fresh_in;
   logic signed [15:0]            sample_ff, sample_in;
   logic [15:0]                   freq_ff, freq_in;
   logic [wrm_pkg::SQ_W-1:0]      square_ff, square_in;
   logic [wrm_pkg::WIN_W-1:0]     window_ff, window_in;

   wrm_pkg::arith_cmd_type        cmd;
   logic                          arith_busy;
   logic                          arith_done;
   logic [wrm_pkg::ACC_W-1:0]     arith_result;

   logic                          req_take;
   logic                          zero_take;
   logic                          arith_wait;
   logic                          cfg_write;
   logic                          reg_index;
   logic [15:0]                   mag;
   logic [31:0]                   mag_sq;
   logic [wrm_pkg::WQ_W-1:0]      wnum;
   logic [wrm_pkg::WQ_W-1:0]      wquot;
   logic [wrm_pkg::SUM_W-1:0]     sum_base;
   logic [wrm_pkg::SUM_W-1:0]     sum_next;
   logic [wrm_pkg::WIN_W-1:0]     count_next;

   wrm_arith_unit u_arith (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .busy   (arith_busy),
      .done   (arith_done),
      .result (arith_result)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign zero_take  = req_take && (req_word.freq == 16'd0);
   assign arith_wait = (state_ff == ST_WDIV) || (state_ff == ST_MDIV) || (state_ff == ST_SQRT);

   // apb register access
   assign pready    = 1'b1;
   assign reg_index = paddr[2];
   assign cfg_write = psel && penable && pwrite && (reg_index == wrm_pkg::REG_SAMPLE_RATE);
   assign prdata    = (reg_index == wrm_pkg::REG_SAMPLE_RATE) ? {16'd0, sample_rate_ff} : 32'd0;
   assign sample_rate_in = cfg_write ? pwdata[15:0] : sample_rate_ff;

   // magnitude and square, window numerator and quotient
   assign mag    = sample_ff[15] ? 16'(-sample_ff) : 16'(sample_ff);
   assign mag_sq = mag * mag;
   assign wnum   = {1'b0, sample_rate_ff} + {2'b00, req_word.freq[15:1]};
   assign wquot  = arith_result[wrm_pkg::WQ_W-1:0];

   assign sum_base   = (freq_ff != stored_freq_ff) ? '0 : square_sum_ff;
   assign sum_next   = sum_base + {(wrm_pkg::SUM_W-wrm_pkg::SQ_W)'(0), square_ff};
   assign count_next = ((freq_ff != stored_freq_ff) ? '0 : sample_count_ff)
                       + wrm_pkg::WIN_W'(1);

   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_word_in     = rsp_word_ff;
      stored_freq_in  = stored_freq_ff;
      square_sum_in   = square_sum_ff;
      sample_count_in = sample_count_ff;
      held_rms_in     = held_rms_ff;
      fresh_in        = fresh_ff;
      sample_in       = sample_ff;
      freq_in         = freq_ff;
      square_in       = square_ff;
      window_in       = window_ff;
      cmd             = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               sample_in = req_word.sample;
               freq_in   = req_word.freq;
               fresh_in  = 1'b0;
               if (req_word.freq == 16'd0) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.start    = 1'b1;
                  cmd.op       = wrm_pkg::OP_DIV;
                  cmd.steps    = wrm_pkg::WDIV_STEPS;
                  cmd.dividend = {wnum, (wrm_pkg::ACC_W-wrm_pkg::WQ_W)'(0)};
                  cmd.divisor  = req_word.freq;
                  state_in     = ST_WDIV;
               end
            end
         end
         ST_WDIV: begin
            square_in = mag_sq[wrm_pkg::SQ_W-1:0];
            if (arith_done) begin
               if (wquot == '0) begin
                  window_in = wrm_pkg::WIN_W'(1);
               end else if (wquot > wrm_pkg::WQ_W'(wrm_pkg::MAX_WINDOW)) begin
                  window_in = wrm_pkg::WIN_W'(wrm_pkg::MAX_WINDOW);
               end else begin
                  window_in = wquot[wrm_pkg::WIN_W-1:0];
               end
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            stored_freq_in = freq_ff;
            if (count_next >= window_ff) begin
               square_sum_in   = '0;
               sample_count_in = '0;
               cmd.start       = 1'b1;
               cmd.op          = wrm_pkg::OP_DIV;
               cmd.steps       = wrm_pkg::MDIV_STEPS;
               cmd.dividend    = {(wrm_pkg::ACC_W-wrm_pkg::SUM_W)'(0), sum_next};
               cmd.divisor     = {(16-wrm_pkg::WIN_W)'(0), window_ff};
               state_in        = ST_MDIV;
            end else begin
               square_sum_in   = sum_next;
               sample_count_in = count_next;
               state_in        = ST_DONE;
            end
         end
         ST_MDIV: begin
            if (arith_done) begin
               cmd.start    = 1'b1;
               cmd.op       = wrm_pkg::OP_SQRT;
               cmd.steps    = wrm_pkg::SQRT_STEPS;
               cmd.dividend = arith_result;
               state_in     = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (arith_done) begin
               held_rms_in = arith_result[15:0];
               fresh_in    = 1'b1;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_word_in.rms   = held_rms_ff;
               rsp_word_in.fresh = fresh_ff;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         sample_rate_ff  <= wrm_pkg::RATE_RESET;
         stored_freq_ff  <= '0;
         square_sum_ff   <= '0;
         sample_count_ff <= '0;
         held_rms_ff     <= '0;
         fresh_ff        <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         sample_rate_ff  <= sample_rate_in;
         stored_freq_ff  <= stored_freq_in;
         square_sum_ff   <= square_sum_in;
         sample_count_ff <= sample_count_in;
         held_rms_ff     <= held_rms_in;
         fresh_ff        <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      sample_ff   <= sample_in;
      freq_ff     <= freq_in;
      square_ff   <= square_in;
      window_ff   <= window_in;
   end

   `ASSERT_IMPLY(a_busy_in_wait, clock, reset, arith_busy, arith_wait)
   `ASSERT_IMPLY(a_done_in_wait, clock, reset, arith_done, arith_wait)
   `ASSERT_NEXT(a_zero_freq_skip, clock, reset, zero_take, (state_ff == ST_DONE && !fresh_ff))

endmodule

### hdl/wrm_arith_unit.sv
// ----------------------------------------------------------------------------
// wrm_arith_unit
// shared bit-serial unit: restoring divide, one quotient bit a cycle, or
// integer square root, one root bit a cycle, over one subtractor
// ----------------------------------------------------------------------------
module wrm_arith_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  wrm_pkg::arith_cmd_type       cmd,
   output logic                         busy,
   output logic                         done,
   output logic [wrm_pkg::ACC_W-1:0]    result
);

   logic                         run_ff, run_in;
   logic                         done_ff, done_in;
   logic                         op_ff, op_in;
   logic [wrm_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [wrm_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [wrm_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic [wrm_pkg::ROOT_W-1:0]   root_ff, root_in;
   logic [15:0]                  divisor_ff, divisor_in;

   logic [wrm_pkg::REM_W-1:0]    shift_a;
   logic [wrm_pkg::REM_W-1:0]    sub_b;
   logic [wrm_pkg::REM_W:0]      diff;
   logic                         ge;

   always_comb begin
      if (op_ff == wrm_pkg::OP_SQRT) begin
         shift_a = {rem_ff[wrm_pkg::REM_W-3:0], acc_ff[wrm_pkg::ACC_W-1 -: 2]};
         sub_b   = {(wrm_pkg::REM_W-wrm_pkg::ROOT_W-2)'(0), root_ff, 2'b01};
      end else begin
         shift_a = {rem_ff[wrm_pkg::REM_W-2:0], acc_ff[wrm_pkg::ACC_W-1]};
         sub_b   = {(wrm_pkg::REM_W-16)'(0), divisor_ff};
      end
      diff = {1'b0, shift_a} - {1'b0, sub_b};
      ge   = ~diff[wrm_pkg::REM_W];
   end

   always_comb begin
      run_in     = run_ff;
      done_in    = 1'b0;
      op_in      = op_ff;
      step_in    = step_ff;
      acc_in     = acc_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      divisor_in = divisor_ff;
      if (cmd.start) begin
         run_in     = 1'b1;
         op_in      = cmd.op;
         step_in    = cmd.steps;
         acc_in     = cmd.dividend;
         rem_in     = '0;
         root_in    = '0;
         divisor_in = cmd.divisor;
      end else if (run_ff) begin
         rem_in  = ge ? diff[wrm_pkg::REM_W-1:0] : shift_a;
         step_in = step_ff - wrm_pkg::STEP_W'(1);
         if (op_ff == wrm_pkg::OP_SQRT) begin
            acc_in  = {acc_ff[wrm_pkg::ACC_W-3:0], 2'b00};
            root_in = {root_ff[wrm_pkg::ROOT_W-2:0], ge};
         end else begin
            acc_in  = {acc_ff[wrm_pkg::ACC_W-2:0], ge};
         end
         if (step_ff == wrm_pkg::STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      step_ff    <= step_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      divisor_ff <= divisor_in;
   end

   assign busy   = run_ff;
   assign done   = done_ff;
   assign result = (op_ff == wrm_pkg::OP_SQRT)
                   ? {(wrm_pkg::ACC_W-wrm_pkg::ROOT_W)'(0), root_ff} : acc_ff;

endmodule

### test/rms_meter_checker.sv
// ----------------------------------------------------------------------------
// rms_meter_checker
// Watches the req, rsp and csr ports of the windowed rms meter. It keeps its
// own copy of sample_rate and of the window state, predicts the rms and fresh
// flag of every accepted req word, and compares each accepted rsp word, field
// by field, with the oldest pending prediction. It also checks csr read-back.
// ----------------------------------------------------------------------------
module rms_meter_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  wrm_pkg::req_word_type req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  wrm_pkg::rsp_word_type rsp_word,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   input  logic [31:0]           prdata,
   input  logic                  pready,
   output int                    words_checked,
   output int                    fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] RATE_ADDR = {wrm_pkg::REG_SAMPLE_RATE, 2'b00};

   logic [15:0]                rate_reg;
   logic [15:0]                win_freq;
   logic [wrm_pkg::SUM_W-1:0]  sq_sum;
   logic [wrm_pkg::WIN_W-1:0]  sq_count;
   logic [15:0]                last_rms;
   wrm_pkg::rsp_word_type      pending_rms[$];

   function automatic logic [15:0] floor_sqrt(input logic [wrm_pkg::SUM_W-1:0] v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 20; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r[15:0];
   endfunction

   function automatic wrm_pkg::rsp_word_type meter_step(input wrm_pkg::req_word_type w);
      int                    span;
      int                    mag;
      wrm_pkg::rsp_word_type r;
      r.fresh = 1'b0;
      if (w.freq != 16'd0) begin
         span = (int'(rate_reg) + int'(w.freq >> 1)) / int'(w.freq);
         if (span < 1) span = 1;
         if (span > wrm_pkg::MAX_WINDOW) span = wrm_pkg::MAX_WINDOW;
         if (w.freq != win_freq) begin
            win_freq = w.freq;
            sq_sum   = '0;
            sq_count = '0;
         end
         mag = (w.sample < 0) ? -int'(w.sample) : int'(w.sample);
         sq_sum   = sq_sum + wrm_pkg::SUM_W'(mag * mag);
         sq_count = sq_count + wrm_pkg::WIN_W'(1);
         if (sq_count >= span) begin
            last_rms = floor_sqrt(sq_sum / span);
            sq_sum   = '0;
            sq_count = '0;
            r.fresh  = 1'b1;
         end
      end
      r.rms = last_rms;
      return r;
   endfunction

   always @(posedge clock) begin
      wrm_pkg::rsp_word_type want;
      int                    bad;
      bad = 0;
      if (reset) begin
         rate_reg = wrm_pkg::RATE_RESET;
         win_freq = '0;
         sq_sum   = '0;
         sq_count = '0;
         last_rms = '0;
         pending_rms.delete();
         words_checked <= 0;
         fail_count    <= 0;
      end else begin
         if (psel && penable && pready && paddr == RATE_ADDR) begin
            if (pwrite) begin
               rate_reg = pwdata[15:0];
            end else if (prdata[15:0] !== rate_reg) begin
               $error("sample_rate: expected %0d, got %0d", rate_reg, prdata[15:0]);
               bad++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rms.size() == 0) begin
               $error("rsp word with no req word pending: rms %0d fresh %0b",
                      rsp_word.rms, rsp_word.fresh);
               bad++;
            end else begin
               want = pending_rms.pop_front();
               if (rsp_word.rms !== want.rms) begin
                  $error("rms: expected %0d, got %0d", want.rms, rsp_word.rms);
                  bad++;
               end
               if (rsp_word.fresh !== want.fresh) begin
                  $error("fresh: expected %0b, got %0b", want.fresh, rsp_word.fresh);
                  bad++;
               end
               words_checked <= words_checked + 1;
            end
         end
         if (req_valid && req_ready) pending_rms.push_back(meter_step(req_word));
         fail_count <= fail_count + bad;
      end
   end

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the windowed rms meter with a directed sequence (zero freq, window
// of one, freq changes, window shrink through a sample_rate rewrite, rate
// extremes, full-scale samples), then random phases of well-formed window
// runs mixed with noise, and one long full-scale window closed by a rate
// rewrite. Bursty req traffic and an rsp stall that is always ready, random,
// sparse or a rotating pattern; the checker module predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CYCLE_LIMIT = 1_500_000;
   localparam int          ITEM_BUDGET = 700;
   localparam int          LONG_RUN    = 300;
   localparam logic [15:0] LONG_RATE   = 16'd19200;
   localparam logic [2:0]  RATE_ADDR   = {wrm_pkg::REG_SAMPLE_RATE, 2'b00};

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   wrm_pkg::req_word_type req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   wrm_pkg::rsp_word_type rsp_word;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [2:0]            paddr     = '0;
   logic [31:0]           pwdata    = '0;
   logic [31:0]           prdata;
   logic                  pready;

   int          words_sent = 0;
   int          words_checked;
   int          fail_count;
   int          cycles     = 0;
   int          burst_left = 0;
   int          stall_left = 0;
   int          stall_mode = 0;
   logic [7:0]  stall_bits = 8'b1101_0011;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   windowed_rms_meter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   rms_meter_checker rms_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .words_checked (words_checked),
      .fail_count    (fail_count)
   );

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(16, 300);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 4) == 0);
         default: rsp_ready <= stall_bits[0];
      endcase
      stall_bits <= {stall_bits[0], stall_bits[7:1]};
   end

   task automatic send_word(input logic signed [15:0] s, input logic [15:0] f);
      req_valid <= 1'b1;
      req_word  <= '{sample: s, freq: f};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 10);
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_checked != words_sent) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write sample_rate, then read it back
   task automatic set_rate(input logic [15:0] v);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      paddr   <= RATE_ADDR;
      pwdata  <= {16'h0000, v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic logic signed [15:0] pick_sample();
      int v;
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: begin
            case ($urandom_range(0, 3))
               0: return 16'sh8000;
               1: return 16'sh7FFF;
               2: return -16'sd1;
               default: return 16'sd0;
            endcase
         end
         2: return 16'(int'($urandom_range(0, 200)) - 100);
         default: begin
            v = $urandom_range(16384, 32767);
            return 16'($urandom_range(0, 1) ? -v : v);
         end
      endcase
   endfunction

   function automatic logic [15:0] freq_for_window(input logic [15:0] rate, input int win);
      int f;
      f = int'(rate) / win;
      if (f < 1) f = 1;
      return f[15:0];
   endfunction

   initial begin
      int          kind;
      int          win;
      int          n;
      logic [15:0] f;
      logic [15:0] cur_rate;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // zero freq right after reset, then windows of one at full scale and at zero
      send_word(16'sh7FFF, 16'd0);
      send_word(16'sh8000, 16'hFFFF);
      send_word(16'sh7FFF, 16'hFFFF);
      send_word(16'sd0, 16'hFFFF);
      send_word(-16'sd1, 16'd0);
      // window of two with an ignored word inside
      send_word(16'sd3, 16'd10000);
      send_word(16'sd7, 16'd0);
      send_word(-16'sd4, 16'd10000);
      // freq change restarts the window
      send_word(16'sd100, 16'd10000);
      send_word(16'sd5, 16'd5000);
      send_word(-16'sd5, 16'd5000);
      send_word(16'sd9, 16'd5000);
      send_word(-16'sd300, 16'd5000);
      // freq of one clamps to the longest window
      send_word(16'sd1234, 16'd1);
      send_word(-16'sd1234, 16'd1);
      // window of ten left open, then shrunk to three by a new rate
      send_word(16'sd77, 16'd2000);
      send_word(-16'sd900, 16'd2000);
      send_word(16'sd31, 16'd2000);
      send_word(16'sh7FFF, 16'd2000);
      wait_for_results();
      set_rate(16'd6000);
      send_word(16'sd50, 16'd2000);
      // rate extremes
      wait_for_results();
      set_rate(16'd1);
      send_word(16'sh8000, 16'd1);
      send_word(16'sd12345, 16'd3);
      wait_for_results();
      set_rate(16'hFFFF);
      send_word(-16'sd2, 16'hFFFF);
      send_word(16'sd200, 16'd64);

      while (words_sent < ITEM_BUDGET - LONG_RUN - 40) begin
         wait_for_results();
         case ($urandom_range(0, 5))
            0: cur_rate = 16'd1;
            1: cur_rate = 16'hFFFF;
            2: cur_rate = wrm_pkg::RATE_RESET;
            default: cur_rate = 16'($urandom_range(1, 65535));
         endcase
         set_rate(cur_rate);
         repeat ($urandom_range(3, 10)) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
               win = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                                 : $urandom_range(1, 12);
               f = freq_for_window(cur_rate, win);
               n = $urandom_range(1, 3 * win + 2);
               repeat (n) begin
                  if ($urandom_range(0, 15) == 0) send_word(pick_sample(), 16'd0);
                  send_word(pick_sample(), f);
               end
            end else if (kind == 7) begin
               repeat ($urandom_range(1, 8)) send_word(16'($urandom), 16'($urandom));
            end else if (kind == 8) begin
               repeat ($urandom_range(1, 4)) send_word(pick_sample(), 16'd0);
            end else begin
               // windows broken off by freq flicker
               repeat ($urandom_range(2, 10)) begin
                  f = freq_for_window(cur_rate, $urandom_range(1, 6));
                  send_word(pick_sample(), f + 16'($urandom_range(0, 1)));
               end
            end
         end
      end

      // long window at full negative scale, closed by a shorter window
      wait_for_results();
      set_rate(16'hFFFF);
      repeat (LONG_RUN - 1) send_word(16'sh8000, 16'd64);
      wait_for_results();
      set_rate(LONG_RATE);
      send_word(16'sh8000, 16'd64);

      wait_for_results();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && words_checked == words_sent) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+hdl
hdl/wrm_pkg.sv
hdl/wrm_arith_unit.sv
hdl/windowed_rms_meter_core.sv
test/rms_meter_checker.sv
test/testbench.sv
